### rtl/dmrg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmrg_pkg: shared constants and types for the downmix resampler
// Holds the register map and the default values of the configuration.
// ----------------------------------------------------------------------------
package dmrg_pkg;
   localparam int MAX_CHANNELS  = 4;
   localparam int MAX_BLOCK     = 4096;
   localparam int HISTORY_DEPTH = 16;
   localparam int MAX_OUT       = 16;

   localparam logic [1:0] REG_CHANNELS = 2'd0;
   localparam logic [1:0] REG_RATIO    = 2'd1;
   localparam logic [1:0] REG_GAIN     = 2'd2;

   localparam logic [2:0]  CHANNELS_RESET = 3'd1;
   localparam logic [19:0] RATIO_RESET    = 20'd65536;
   localparam logic [19:0] RATIO_MIN      = 20'd16384;
   localparam logic [15:0] GAIN_RESET     = 16'd4096;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SUM   = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_MUL1  = 7'b0010000,
      ST_MUL2  = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;
endpackage
`default_nettype wire

### rtl/downmix_resample_gain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// downmix_resample_gain: downmix, linear resampling, gain and saturation
// One multichannel frame in, zero or more resampled mono samples out.
// ----------------------------------------------------------------------------
// Usage: each req transaction carries one frame (four Q1.15 channel samples
// and a last-frame flag in tlast). Active channels are summed one per cycle
// and averaged; the sample goes into a small history memory. Outputs due
// at the current source position are then interpolated one by one through
// one shared multiplier: two products for the interpolation terms, then two
// for the gain (upper and lower half of the interpolated value). Each output
// is held until the next is computed, so the final one of a block can carry
// tlast.
// Flow control: req_tready is low until the frame is fully done, and stays low
// while the result register is occupied and the receiver stalls.
// Reset clears the control state and returns the registers to their
// defaults; history contents are undefined until written.
// ----------------------------------------------------------------------------
module downmix_resample_gain #(
   parameter int MAX_BLOCK     = dmrg_pkg::MAX_BLOCK
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // ch0_sample[15:0], ch1_sample[31:16], ch2_sample[47:32], ch3_sample[63:48]
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tlast,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_sample[15:0]
   output      logic [15:0] rsp_tdata,
   output      logic        rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   localparam int MAX_CHANNELS  = dmrg_pkg::MAX_CHANNELS;
   localparam int HISTORY_DEPTH = dmrg_pkg::HISTORY_DEPTH;
   localparam int HW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(MAX_CHANNELS + 1);
   localparam int BW = $clog2(MAX_BLOCK + 1);
   localparam int PW = BW + 17;

   logic [2:0]  chan_ff;
   logic [19:0] ratio_ff;
   logic [15:0] gain_ff;
   logic        wr;
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= dmrg_pkg::CHANNELS_RESET;
         ratio_ff <= dmrg_pkg::RATIO_RESET;
         gain_ff  <= dmrg_pkg::GAIN_RESET;
      end else if (wr) begin
         unique case (csr_paddr[3:2])
            dmrg_pkg::REG_CHANNELS: chan_ff  <= csr_pwdata[2:0];
            dmrg_pkg::REG_RATIO:    ratio_ff <= csr_pwdata[19:0];
            dmrg_pkg::REG_GAIN:     gain_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         dmrg_pkg::REG_CHANNELS: csr_prdata = {29'd0, chan_ff};
         dmrg_pkg::REG_RATIO:    csr_prdata = {12'd0, ratio_ff};
         dmrg_pkg::REG_GAIN:     csr_prdata = {16'd0, gain_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   // Effective channel count and ratio.
   logic [CW-1:0] nch;
   logic [19:0]   ratio;
   always_comb begin
      if (chan_ff == 3'd0) nch = CW'(1);
      else if (32'(chan_ff) > MAX_CHANNELS) nch = CW'(MAX_CHANNELS);
      else nch = CW'(chan_ff);
      ratio = (ratio_ff < dmrg_pkg::RATIO_MIN) ? dmrg_pkg::RATIO_MIN : ratio_ff;
   end

   dmrg_pkg::state_type state_ff, state_in;
   logic [63:0]   frame_ff;
   logic          lastf_ff;
   logic [CW-1:0] k_ff;
   logic signed [18:0] sum_ff;
   logic [BW-1:0] seen_ff;       // frames stored in this block
   logic [PW-1:0] pos_ff;
   logic          first_ff;
   logic          held_v_ff;
   logic [15:0]   held_ff;
   logic [4:0]    cnt_ff;        // outputs computed this frame
   logic signed [15:0] hist [HISTORY_DEPTH];
   logic [HW-1:0] rd_addr;
   logic signed [15:0] rd_ff;
   logic signed [15:0] s1_ff;
   logic signed [49:0] acc_ff;
   logic          out_v_ff;
   logic [15:0]   out_d_ff;
   logic          out_l_ff;

   // Mono sample: truncating divide by the channel count (1..MAX_CHANNELS),
   // done as a small constant-reciprocal table on the magnitude.
   logic [18:0] mag;
   logic [15:0] quo;
   logic signed [15:0] mono;
   always_comb begin
      mag = sum_ff[18] ? 19'(-sum_ff) : 19'(sum_ff);
      unique case (nch)
         CW'(3):  quo = 16'((38'(mag) * 38'd87382) >> 18);
         CW'(2):  quo = 16'(mag >> 1);
         CW'(4):  quo = 16'(mag >> 2);
         default: quo = 16'(mag);
      endcase
      mono = sum_ff[18] ? -$signed(quo) : $signed(quo);
   end

   // Shared multiplier: 19-bit signed by 18-bit signed.
   logic signed [18:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [36:0] mul_p;
   logic [16:0] frac;
   logic [BW-1:0] m;   // block length including this frame
   logic [PW-1:0] i1;
   logic          lst;
   logic          due, exists;
   assign frac = {1'b0, pos_ff[15:0]};
   assign m    = seen_ff + BW'(1);
   assign lst  = lastf_ff || (32'(m) >= MAX_BLOCK);
   assign i1   = pos_ff >> 16;
   assign due  = lst || (i1 + PW'(1) < PW'(m));
   assign exists = first_ff ||
      (({1'b0, pos_ff} << 1) + (PW+1)'(ratio)) <= ((PW+1)'(m) << 17);

   // Interpolation plus gain: s1*(65536-f) + s2*f, then * gain in two halves.
   logic [BW-1:0] idx1, idx2;
   always_comb begin
      idx1 = (i1 > PW'(m - BW'(1))) ? m - BW'(1) : BW'(i1);
      idx2 = (i1 + PW'(1) > PW'(m - BW'(1))) ? m - BW'(1) : BW'(i1 + PW'(1));
   end

   logic [63:0] u;
   logic signed [35:0] q;
   logic [15:0] sat;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == dmrg_pkg::ST_MUL1) begin
         mul_a = 19'(s1_ff);
         mul_b = $signed(18'(17'd65536 - frac));
      end else if (state_ff == dmrg_pkg::ST_MUL2) begin
         if (phase_ff == 3'd3) begin
            mul_a = 19'(rd_ff);
            mul_b = $signed({1'b0, frac});
         end else if (phase_ff == 3'd4) begin
            mul_a = $signed({3'b000, gain_ff});
            mul_b = 18'($signed(acc_ff[33:17]));
         end else begin
            mul_a = $signed({3'b000, gain_ff});
            mul_b = $signed({1'b0, acc_ff[16:0]});
         end
      end
      mul_p = mul_a * mul_b;
      u = 64'(acc_ff) + 64'h0000_0000_0800_0000 + 64'h4000_0000_0000_0000;
      q = 36'($signed(u >> 28) - 64'sh4_0000_0000);
      if (q > 36'sd32767) sat = 16'h7fff;
      else if (q < -36'sd32768) sat = 16'h8000;
      else sat = q[15:0];
   end

   logic [2:0] phase_ff;   // within the output sequence
   logic       out_free;
   logic       out_load;
   assign out_free = !out_v_ff || rsp_tready;
   assign out_load = (state_ff == dmrg_pkg::ST_EMIT) && out_free &&
                     (phase_ff == 3'd0 || held_v_ff);
   assign rd_addr = (phase_ff == 3'd0) ? HW'(idx1) : HW'(idx2);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmrg_pkg::ST_IDLE:  if (req_tvalid) state_in = dmrg_pkg::ST_SUM;
         dmrg_pkg::ST_SUM:   if (k_ff == nch) state_in = dmrg_pkg::ST_DIV;
         dmrg_pkg::ST_DIV:   state_in = dmrg_pkg::ST_CHECK;
         dmrg_pkg::ST_CHECK: begin
            if (due && exists && cnt_ff < 5'd15) state_in = dmrg_pkg::ST_MUL1;
            else if (lst && held_v_ff) state_in = dmrg_pkg::ST_EMIT;
            else state_in = dmrg_pkg::ST_IDLE;
         end
         dmrg_pkg::ST_MUL1:  if (phase_ff == 3'd2) state_in = dmrg_pkg::ST_MUL2;
         dmrg_pkg::ST_MUL2:  if (phase_ff == 3'd5) state_in = dmrg_pkg::ST_EMIT;
         dmrg_pkg::ST_EMIT:  if (out_free) state_in = dmrg_pkg::ST_CHECK;
         default:            state_in = dmrg_pkg::ST_IDLE;
      endcase
      if (state_ff == dmrg_pkg::ST_EMIT && out_free && phase_ff == 3'd0)
         state_in = dmrg_pkg::ST_IDLE;
   end

   assign req_tready = (state_ff == dmrg_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (state_ff == dmrg_pkg::ST_DIV) hist[HW'(seen_ff)] <= mono;
      rd_ff <= hist[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dmrg_pkg::ST_IDLE;
         seen_ff   <= '0;
         pos_ff    <= '0;
         first_ff  <= 1'b1;
         held_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         phase_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
         unique case (state_ff)
            dmrg_pkg::ST_IDLE: if (req_tvalid) begin
               frame_ff <= req_tdata;
               lastf_ff <= req_tlast;
               k_ff     <= '0;
               sum_ff   <= '0;
               cnt_ff   <= '0;
            end
            dmrg_pkg::ST_SUM: if (k_ff != nch) begin
               sum_ff <= sum_ff + 19'($signed(frame_ff[16*k_ff[1:0] +: 16]));
               k_ff   <= k_ff + CW'(1);
            end
            dmrg_pkg::ST_CHECK: phase_ff <= 3'd0;
            dmrg_pkg::ST_MUL1: begin
               // read s1; then capture s1 and read s2; then form the s1 term
               phase_ff <= phase_ff + 3'd1;
               if (phase_ff == 3'd1) s1_ff <= rd_ff;
               if (phase_ff == 3'd2) acc_ff <= 50'(mul_p);
            end
            dmrg_pkg::ST_MUL2: begin
               // add the s2 term; then gain times the upper and then the lower
               // 17 bits of the interpolated value
               phase_ff <= phase_ff + 3'd1;
               if (phase_ff == 3'd3) acc_ff <= acc_ff + 50'(mul_p);
               if (phase_ff == 3'd4) acc_ff <= {33'(mul_p), acc_ff[16:0]};
               if (phase_ff == 3'd5) acc_ff <= $signed({acc_ff[49:17], 17'd0}) + 50'(mul_p);
            end
            dmrg_pkg::ST_EMIT: if (out_free) begin
               if (phase_ff == 3'd0) begin
                  // block-end flush of the held output
                  out_d_ff  <= held_ff;
                  out_l_ff  <= 1'b1;
                  held_v_ff <= 1'b0;
                  seen_ff   <= '0;
                  pos_ff    <= '0;
                  first_ff  <= 1'b1;
               end else begin
                  if (held_v_ff) begin
                     out_d_ff <= held_ff;
                     out_l_ff <= 1'b0;
                  end
                  held_ff   <= sat;
                  held_v_ff <= 1'b1;
                  pos_ff    <= pos_ff + PW'(ratio);
                  first_ff  <= 1'b0;
                  cnt_ff    <= cnt_ff + 5'd1;
                  phase_ff  <= 3'd0;
               end
            end
            default: ;
         endcase
         if (state_ff == dmrg_pkg::ST_CHECK && state_in == dmrg_pkg::ST_IDLE) begin
            if (lst) begin
               seen_ff  <= '0;
               pos_ff   <= '0;
               first_ff <= 1'b1;
               held_v_ff <= 1'b0;
            end else begin
               seen_ff <= m;
            end
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tlast  = out_l_ff;
endmodule
`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for downmix_resample_gain
// Streams multichannel frames in through a randomly gapped driver, predicts the
// resampled output stream in a behavioral model kept in step with the accepted
// frames, and compares every output transaction against the oldest prediction.
// The register settings are changed between phases, each with the block idle.
// ----------------------------------------------------------------------------
module tb_top;
   typedef struct {
      logic [63:0] data;
      logic        last;
   } frame_type;

   typedef struct {
      logic [15:0] sample;
      logic        last;
   } mono_out_type;

   localparam int SETTLE_CYCLES = 120;
   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // ch0[15:0], ch1[31:16], ch2[47:32], ch3[63:48]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // out_sample[15:0]
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   downmix_resample_gain uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   frame_type    pending_frames[$];
   mono_out_type expected_samples[$];
   int          error_count = 0;
   bit          no_gaps = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   // Predictor copy of the registers and the block state.
   logic [2:0]         cfg_channels;
   logic [19:0]        cfg_ratio;
   logic [15:0]        cfg_gain;
   logic signed [15:0] mono_hist [dmrg_pkg::HISTORY_DEPTH];
   int                 frame_count;
   longint             out_pos;
   bit                 first_pending;
   bit                 held_valid;
   logic [15:0]        held_sample;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("tb_top: mismatch: %s", what);
   endtask

   function automatic logic [15:0] interpolate(input longint pos, input int m);
      longint i1, i2, f, s1, s2, acc, q;
      i1 = pos >>> 16;
      i2 = i1 + 1;
      f  = pos & 64'hFFFF;
      if (i1 > m - 1) i1 = m - 1;
      if (i2 > m - 1) i2 = m - 1;
      s1  = longint'(mono_hist[i1 % dmrg_pkg::HISTORY_DEPTH]);
      s2  = longint'(mono_hist[i2 % dmrg_pkg::HISTORY_DEPTH]);
      acc = (s1 * (65536 - f) + s2 * f) * longint'({48'd0, cfg_gain});
      q   = (acc + (64'sd1 <<< 27)) >>> 28;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   // Downmix one frame, then produce the outputs whose neighbors are now known, up to the per-frame cap.
   task automatic resample_frame(input logic [63:0] data, input logic last_flag);
      int     nch, sum, m, count;
      bit     block_end, exists;
      longint r, i1;
      logic [15:0] v;
      nch = cfg_channels;
      if (nch < 1) nch = 1;
      if (nch > dmrg_pkg::MAX_CHANNELS) nch = dmrg_pkg::MAX_CHANNELS;
      sum = 0;
      for (int k = 0; k < nch; k++) sum += int'($signed(data[16*k +: 16]));
      mono_hist[frame_count % dmrg_pkg::HISTORY_DEPTH] = 16'(sum / nch);
      m = frame_count + 1;
      block_end = last_flag || m >= dmrg_pkg::MAX_BLOCK;
      r = (cfg_ratio < dmrg_pkg::RATIO_MIN) ? longint'(dmrg_pkg::RATIO_MIN)
                                            : longint'(cfg_ratio);
      count = 0;
      while (count < dmrg_pkg::MAX_OUT - 1) begin
         i1 = out_pos >>> 16;
         if (!block_end && i1 + 1 >= m) break;
         exists = first_pending || (2 * out_pos + r <= (longint'(m) <<< 17));
         if (!exists) break;
         v = interpolate(out_pos, m);
         if (held_valid) begin
            expected_samples.push_back('{held_sample, 1'b0});
            count++;
         end
         held_sample = v;
         held_valid = 1;
         out_pos += r;
         first_pending = 0;
      end
      if (block_end) begin
         if (held_valid) expected_samples.push_back('{held_sample, 1'b1});
         frame_count = 0;
         out_pos = 0;
         first_pending = 1;
         held_valid = 0;
      end else begin
         frame_count = m;
      end
   endtask

   // Driver: takes frames from the pending queue and predicts on acceptance.
   always @(posedge clock) begin
      frame_type fr;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) resample_frame(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (pending_frames.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 10))
            begin
               fr = pending_frames.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= fr.data;
               req_tlast <= fr.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure, long hold-offs on request, field checks.
   always @(posedge clock) begin
      mono_out_type exp_s;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected sample %h last %b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               exp_s = expected_samples.pop_front();
               if (rsp_tdata !== exp_s.sample)
                  report_mismatch($sformatf("sample %h, predicted %h", rsp_tdata,
                                            exp_s.sample));
               if (rsp_tlast !== exp_s.last)
                  report_mismatch($sformatf("last %b, predicted %b", rsp_tlast,
                                            exp_s.last));
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_gaps || $urandom_range(0, 99) >= 10;
         end
      end
   end

   // Watchdog on cycles in which no transaction moves on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (pending_frames.size() > 0 || req_tvalid || expected_samples.size() > 0)
         @(posedge clock);
   endtask

   task automatic csr_access(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                             input logic [31:0] mask);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (!wr && (csr_prdata & mask) !== (wdata & mask))
         report_mismatch($sformatf("register %0d reads %h, written %h", idx, csr_prdata,
                                   wdata & mask));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Writes all three registers with the block idle, then reads them back.
   task automatic set_config(input logic [2:0] ch, input logic [19:0] ratio,
                             input logic [15:0] g);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(dmrg_pkg::REG_CHANNELS, 1'b1, {29'd0, ch}, 32'h7);
      csr_access(dmrg_pkg::REG_RATIO, 1'b1, {12'd0, ratio}, 32'hFFFFF);
      csr_access(dmrg_pkg::REG_GAIN, 1'b1, {16'd0, g}, 32'hFFFF);
      cfg_channels = ch;
      cfg_ratio = ratio;
      cfg_gain = g;
      csr_access(dmrg_pkg::REG_CHANNELS, 1'b0, {29'd0, ch}, 32'h7);
      csr_access(dmrg_pkg::REG_RATIO, 1'b0, {12'd0, ratio}, 32'hFFFFF);
      csr_access(dmrg_pkg::REG_GAIN, 1'b0, {16'd0, g}, 32'hFFFF);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_block(input int len);
      for (int n = 0; n < len; n++)
         pending_frames.push_back('{{pick_sample(), pick_sample(), pick_sample(), pick_sample()},
                                    n == len - 1});
   endtask

   task automatic queue_fill(input logic [15:0] s, input int len);
      for (int n = 0; n < len; n++)
         pending_frames.push_back('{{4{s}}, n == len - 1});
   endtask

   initial begin
      logic [19:0] ratio;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_channels = dmrg_pkg::CHANNELS_RESET;
      cfg_ratio = dmrg_pkg::RATIO_RESET;
      cfg_gain = dmrg_pkg::GAIN_RESET;
      frame_count = 0;
      out_pos = 0;
      first_pending = 1;
      held_valid = 0;
      held_sample = '0;
      foreach (mono_hist[k]) mono_hist[k] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Defaults: full-scale extremes and a single-frame block.
      queue_fill(16'h7FFF, 3);
      queue_fill(16'h8000, 2);
      queue_fill(16'h1234, 1);
      // Finest ratio with the highest gain saturates both ways.
      set_config(3'd4, dmrg_pkg::RATIO_MIN, 16'hFFFF);
      queue_fill(16'h8000, 3);
      queue_block(4);
      // Ratio below the floor, channel count zero, muted output.
      set_config(3'd0, 20'd0, 16'd0);
      queue_block(4);
      // Coarsest ratio with a channel count above the maximum.
      set_config(3'd7, 20'hFFFFF, dmrg_pkg::GAIN_RESET);
      queue_block(8);

      for (int phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 3))
            0: ratio = dmrg_pkg::RATIO_MIN;
            1: ratio = 20'hFFFFF;
            default: ratio = 20'($urandom_range(0, 20'hFFFFF));
         endcase
         set_config(3'($urandom_range(0, 7)), ratio, 16'($urandom));
         no_gaps = (phase == 3);
         if (phase == 1) hold_requests++;
         for (int b = 0; b < 3; b++) begin
            queue_block($urandom_range(1, 12));
            if (phase == 2 && b == 1) wait_drained();
         end
      end
      no_gaps = 0;
      queue_block(2);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule
